// ----- sv/positional_array_list_defines.svh -----
// Assertion helpers used by the checker module.
`ifndef POSITIONAL_ARRAY_LIST_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_DEFINES_SVH

// Check a condition on every enabled clock edge.
`define PAL_CHECK(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle.
`define PAL_CHECK_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a trigger implies a consequence in the next cycle.
`define PAL_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/pal_pkg.sv -----
`default_nettype none

package pal_pkg;

   // Field widths of the request and response channels
   localparam int OP_W     = 3;
   localparam int POS_W    = 5;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 5;

   // Operation codes
   localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
   localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
   localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
   localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;
   localparam logic [OP_W-1:0] OP_READ      = 3'd6;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_PUT,
      S_READ,
      S_READ_CAP,
      S_DONE
   } state_type;

   // Finished result handed from the sequencer to the response register
   typedef struct packed {
      logic                     load;
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] read_value;
      logic [LEN_W-1:0]         length;
   } result_type;

endpackage

`default_nettype wire

// ----- sv/pal_if.sv -----
`default_nettype none

// Request channel: one list operation per transfer
interface pal_req_if;
   logic                              valid;
   logic                              ready;
   logic [pal_pkg::OP_W-1:0]          operation;
   logic [pal_pkg::POS_W-1:0]         position;
   logic signed [pal_pkg::DATA_W-1:0] value;

   modport source (output valid, output operation, output position, output value,
                   input ready);
   modport sink   (input valid, input operation, input position, input value,
                   output ready);
endinterface

// Response channel: one result per request
interface pal_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [pal_pkg::STATUS_W-1:0]      status;
   logic signed [pal_pkg::DATA_W-1:0] read_value;
   logic [pal_pkg::LEN_W-1:0]         length;

   modport source (output valid, output status, output read_value, output length,
                   input ready);
   modport sink   (input valid, input status, input read_value, input length,
                   output ready);
endinterface

`default_nettype wire

// ----- sv/positional_array_list.sv -----
// A refused request, a back delete or an unused code goes straight to S_DONE; a read
// passes S_READ and S_READ_CAP; each moved element takes S_SHIFT_RD then S_SHIFT_WR,
// as the store has one write and one registered read port; an insert then adds S_PUT.
// No new request is taken until S_DONE has handed its result to a free response slot.
// Reset (synchronous, active high) empties the list and clears both handshakes; store
// contents are left as they are and never read before they are written.
`default_nettype none

module positional_array_list #(
   parameter int CAPACITY = 16
) (
   input wire logic   clock,
   input wire logic   reset,
   pal_req_if.sink    req_bus,
   pal_rsp_if.source  rsp_bus
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   pal_pkg::result_type               result;
   logic                              rsp_free;
   logic                              ram_we;
   logic [IW-1:0]                     ram_waddr;
   logic [pal_pkg::DATA_W-1:0]        ram_wdata;
   logic [IW-1:0]                     ram_raddr;
   logic [pal_pkg::DATA_W-1:0]        ram_rdata;

   logic                              rsp_valid_ff;
   logic [pal_pkg::STATUS_W-1:0]      rsp_status_ff;
   logic signed [pal_pkg::DATA_W-1:0] rsp_read_value_ff;
   logic [pal_pkg::LEN_W-1:0]         rsp_length_ff;

   pal_ctrl #(
      .CAPACITY(CAPACITY)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_operation (req_bus.operation),
      .req_position  (req_bus.position),
      .req_value     (req_bus.value),
      .req_ready     (req_bus.ready),
      .rsp_free      (rsp_free),
      .ram_we        (ram_we),
      .ram_waddr     (ram_waddr),
      .ram_wdata     (ram_wdata),
      .ram_raddr     (ram_raddr),
      .ram_rdata     (ram_rdata),
      .result        (result)
   );

   pal_ram #(
      .WIDTH(pal_pkg::DATA_W),
      .DEPTH(CAPACITY)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Free the response slot when it is empty or its transfer completes now
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   // Hold the result until the response transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (result.load) begin
         rsp_status_ff     <= result.status;
         rsp_read_value_ff <= result.read_value;
         rsp_length_ff     <= result.length;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.read_value = rsp_read_value_ff;
   assign rsp_bus.length     = rsp_length_ff;

endmodule

`default_nettype wire

// ----- sv/pal_ram.sv -----
`default_nettype none

module pal_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                       clock,
   input  wire logic                       we,
   input  wire logic [AW-1:0]              waddr,
   input  wire logic [WIDTH-1:0]           wdata,
   input  wire logic [AW-1:0]              raddr,
   output logic      [WIDTH-1:0]           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- sv/pal_ctrl.sv -----
`default_nettype none

module pal_ctrl #(
   parameter int CAPACITY = 16,
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic [pal_pkg::OP_W-1:0]          req_operation,
   input  wire logic [pal_pkg::POS_W-1:0]         req_position,
   input  wire logic signed [pal_pkg::DATA_W-1:0] req_value,
   output logic                                   req_ready,
   input  wire logic                              rsp_free,
   output logic                                   ram_we,
   output logic [IW-1:0]                          ram_waddr,
   output logic [pal_pkg::DATA_W-1:0]             ram_wdata,
   output logic [IW-1:0]                          ram_raddr,
   input  wire logic [pal_pkg::DATA_W-1:0]        ram_rdata,
   output pal_pkg::result_type                    result
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > pal_pkg::POS_W) ? CW : pal_pkg::POS_W;
   localparam int LW = pal_pkg::LEN_W;

   pal_pkg::state_type                state_ff, state_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic [IW-1:0]                     cursor_ff, cursor_in;
   logic [IW-1:0]                     limit_ff, limit_in;
   logic                              insert_ff, insert_in;
   logic signed [pal_pkg::DATA_W-1:0] value_ff, value_in;
   logic [pal_pkg::STATUS_W-1:0]      status_ff, status_in;
   logic signed [pal_pkg::DATA_W-1:0] rdval_ff, rdval_in;

   logic [IW-1:0] step;
   logic [PW-1:0] pos_ext;
   logic [PW-1:0] cnt_ext;
   logic          is_full;
   logic          is_empty;

   // Shared index stepper: move the cursor one place toward the gap end
   assign step     = insert_ff ? (cursor_ff - IW'(1)) : (cursor_ff + IW'(1));
   assign pos_ext  = PW'(req_position);
   assign cnt_ext  = PW'(count_ff);
   assign is_full  = (count_ff == CW'(CAPACITY));
   assign is_empty = (count_ff == '0);

   // Hold state and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pal_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      cursor_ff <= cursor_in;
      limit_ff  <= limit_in;
      insert_ff <= insert_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      rdval_ff  <= rdval_in;
   end

   // Decode requests and sequence the shift, put and read through the store
   always_comb begin
      logic [IW-1:0] at;
      logic [IW-1:0] last;
      at         = '0;
      last       = IW'(count_ff - CW'(1));
      state_in   = state_ff;
      count_in   = count_ff;
      cursor_in  = cursor_ff;
      limit_in   = limit_ff;
      insert_in  = insert_ff;
      value_in   = value_ff;
      status_in  = status_ff;
      rdval_in   = rdval_ff;
      req_ready  = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = cursor_ff;
      ram_wdata  = ram_rdata;
      ram_raddr  = cursor_ff;
      result.load       = 1'b0;
      result.status     = status_ff;
      result.read_value = rdval_ff;
      result.length     = LW'(count_ff);

      case (state_ff)
         pal_pkg::S_IDLE: begin
            req_ready = !reset;
            if (req_valid && req_ready) begin
               value_in  = req_value;
               rdval_in  = '0;
               status_in = pal_pkg::ST_OK;
               state_in  = pal_pkg::S_DONE;
               case (req_operation)
                  pal_pkg::OP_INS_FRONT, pal_pkg::OP_INS_BACK, pal_pkg::OP_INS_AT: begin
                     if (is_full) begin
                        status_in = pal_pkg::ST_FULL;
                     end else if (req_operation == pal_pkg::OP_INS_AT && pos_ext > cnt_ext) begin
                        status_in = pal_pkg::ST_BADPOS;
                     end else begin
                        if (req_operation == pal_pkg::OP_INS_BACK) begin
                           at = IW'(count_ff);
                        end else if (req_operation == pal_pkg::OP_INS_AT) begin
                           at = IW'(req_position);
                        end
                        cursor_in = IW'(count_ff);
                        limit_in  = at;
                        insert_in = 1'b1;
                        count_in  = count_ff + CW'(1);
                        state_in  = (IW'(count_ff) > at) ? pal_pkg::S_SHIFT_RD
                                                         : pal_pkg::S_PUT;
                     end
                  end
                  pal_pkg::OP_DEL_FRONT, pal_pkg::OP_DEL_BACK, pal_pkg::OP_DEL_AT: begin
                     if (is_empty) begin
                        status_in = pal_pkg::ST_EMPTY;
                     end else if (req_operation == pal_pkg::OP_DEL_BACK) begin
                        count_in = count_ff - CW'(1);
                     end else if (req_operation == pal_pkg::OP_DEL_AT && pos_ext >= cnt_ext) begin
                        status_in = pal_pkg::ST_BADPOS;
                     end else begin
                        if (req_operation == pal_pkg::OP_DEL_AT) begin
                           at = IW'(req_position);
                        end
                        cursor_in = at;
                        limit_in  = last;
                        insert_in = 1'b0;
                        count_in  = count_ff - CW'(1);
                        state_in  = (at < last) ? pal_pkg::S_SHIFT_RD : pal_pkg::S_DONE;
                     end
                  end
                  pal_pkg::OP_READ: begin
                     if (is_empty) begin
                        status_in = pal_pkg::ST_EMPTY;
                     end else if (pos_ext >= cnt_ext) begin
                        status_in = pal_pkg::ST_BADPOS;
                     end else begin
                        cursor_in = IW'(req_position);
                        state_in  = pal_pkg::S_READ;
                     end
                  end
                  default: begin
                     state_in = pal_pkg::S_DONE;
                  end
               endcase
            end
         end
         pal_pkg::S_SHIFT_RD: begin
            ram_raddr = step;
            state_in  = pal_pkg::S_SHIFT_WR;
         end
         pal_pkg::S_SHIFT_WR: begin
            ram_we    = 1'b1;
            ram_waddr = cursor_ff;
            ram_wdata = ram_rdata;
            cursor_in = step;
            if (insert_ff) begin
               state_in = (step > limit_ff) ? pal_pkg::S_SHIFT_RD : pal_pkg::S_PUT;
            end else begin
               state_in = (step < limit_ff) ? pal_pkg::S_SHIFT_RD : pal_pkg::S_DONE;
            end
         end
         pal_pkg::S_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = limit_ff;
            ram_wdata = value_ff;
            state_in  = pal_pkg::S_DONE;
         end
         pal_pkg::S_READ: begin
            ram_raddr = cursor_ff;
            state_in  = pal_pkg::S_READ_CAP;
         end
         pal_pkg::S_READ_CAP: begin
            rdval_in = ram_rdata;
            state_in = pal_pkg::S_DONE;
         end
         pal_pkg::S_DONE: begin
            result.load = rsp_free;
            if (rsp_free) begin
               state_in = pal_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pal_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- sv/pal_checker.sv -----
`default_nettype none
`include "positional_array_list_defines.svh"

module pal_checker #(
   parameter int CAPACITY = 16
) (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [pal_pkg::STATUS_W-1:0]      rsp_status,
   input wire logic signed [pal_pkg::DATA_W-1:0] rsp_read_value,
   input wire logic [pal_pkg::LEN_W-1:0]         rsp_length
);

   localparam int LW = pal_pkg::LEN_W;

   logic rsp_stall;
   logic rsp_refused;
   logic rsp_full;
   logic rsp_empty;

   // Classify the response on the bus
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_refused = rsp_valid && rsp_status != pal_pkg::ST_OK;
   assign rsp_full    = rsp_valid && rsp_status == pal_pkg::ST_FULL;
   assign rsp_empty   = rsp_valid && rsp_status == pal_pkg::ST_EMPTY;

   // A stalled response stays up
   `PAL_CHECK_NEXT(a_rsp_hold, rsp_stall, rsp_valid, "response dropped while stalled")

   // A refused request reads back zero
   `PAL_CHECK_SAME(a_err_zero, rsp_refused, rsp_read_value == '0, "refused request read nonzero")

   // A full refusal reports the capacity as length
   `PAL_CHECK_SAME(a_full_len, rsp_full, rsp_length == LW'(CAPACITY), "bad length on full")

   // An empty refusal reports an empty list
   `PAL_CHECK(a_empty_len, !rsp_empty || rsp_length == '0, "bad length on empty")

endmodule

bind positional_array_list pal_checker #(
   .CAPACITY(CAPACITY)
) u_pal_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_status     (rsp_bus.status),
   .rsp_read_value (rsp_bus.read_value),
   .rsp_length     (rsp_bus.length)
);

`default_nettype wire
